// ----- rtl/bds_pkg.sv -----
// Shared constants, register indexes and stage types for the 2x2 box downscaler.
package bds_pkg;

   // Largest supported source side, as a base-two logarithm
   localparam int MAX_WIDTH_LOG2 = 12;

   // Widths of configuration, counters and line buffer addressing
   localparam int LOG2_W     = 4;
   localparam int CNT_W      = MAX_WIDTH_LOG2;
   localparam int SLOT_W     = MAX_WIDTH_LOG2 - 1;
   localparam int LINE_DEPTH = 1 << SLOT_W;

   // Pixel and pair-sum layout
   localparam int CHANNELS = 4;
   localparam int CHAN_W   = 8;
   localparam int PIX_W    = CHANNELS * CHAN_W;
   localparam int PAIR_W   = CHAN_W + 1;
   localparam int LINE_W   = CHANNELS * PAIR_W;

   // Configuration port
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] REG_WIDTH_LOG2  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_HEIGHT_LOG2 = CSR_INDEX_W'(1);

   localparam logic [LOG2_W-1:0] MAX_LOG2_CFG = LOG2_W'(MAX_WIDTH_LOG2);
   localparam logic [LOG2_W-1:0] LOG2_RESET   = LOG2_W'(1);

   // Control carried with a pixel from the input stage to the averaging stage
   typedef struct packed {
      logic emit;    // this transaction produces a result
      logic err;     // image is 1x1
      logic two_d;   // 2x2 block mode, otherwise pair mode
      logic last;    // final result of the frame
   } bds_ctl_type;

endpackage

// ----- rtl/box_downscale_2x2_core.sv -----
// Top level of the streaming 2x2 box-filter mip-level generator.
// Source pixels (four 8-bit channels) enter in raster order, one transaction per clock
// cycle while a full result register is not held by rsp_tready. Each result passes the
// input stage, where the counters step and the line buffer is read, and is registered
// there, then the averaging stage, which writes it into the result register. The single
// line buffer is a 2048 x 36 RAM with one write and one registered read port; even rows
// write a pair sum there and odd rows read it, never in the same cycle. The buffer has no
// clearing pass, so the block is ready straight after reset. A write to either configuration
// register restarts the frame; write only while no transaction is in flight.
module box_downscale_2x2_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bds_pkg::PIX_W-1:0]       req_tdata,  // chan0, chan1, chan2, chan3
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bds_pkg::PIX_W-1:0]       rsp_tdata,  // avg0, avg1, avg2, avg3
   output logic                            rsp_tlast,  // frame_end
   output logic                            rsp_tuser,  // size_error
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bds_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bds_pkg::LOG2_W-1:0]      csr_data
);
   import bds_pkg::*;

   logic              s1_valid, s1_advance;
   bds_ctl_type       s1_ctl;
   logic [PIX_W-1:0]  s1_left, s1_pix;
   logic              line_wr_en, line_rd_en;
   logic [SLOT_W-1:0] line_wr_addr, line_rd_addr;
   logic [LINE_W-1:0] line_wr_data, line_rd_data;

   // Counters, configuration and line buffer addressing
   bds_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .s1_advance   (s1_advance),
      .s1_valid     (s1_valid),
      .s1_ctl       (s1_ctl),
      .s1_left      (s1_left),
      .s1_pix       (s1_pix),
      .line_wr_en   (line_wr_en),
      .line_wr_addr (line_wr_addr),
      .line_wr_data (line_wr_data),
      .line_rd_en   (line_rd_en),
      .line_rd_addr (line_rd_addr)
   );

   // Pair-sum line buffer
   bds_ram #(
      .WIDTH (LINE_W),
      .DEPTH (LINE_DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (line_wr_en),
      .wr_addr (line_wr_addr),
      .wr_data (line_wr_data),
      .rd_en   (line_rd_en),
      .rd_addr (line_rd_addr),
      .rd_data (line_rd_data)
   );

   // Averages and result register
   bds_average u_average (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid),
      .s1_ctl     (s1_ctl),
      .s1_left    (s1_left),
      .s1_pix     (s1_pix),
      .above      (line_rd_data),
      .s1_advance (s1_advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- rtl/bds_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bds_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, and read port that holds its data until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bds_front.sv -----
// Input stage: configuration, raster counters, left pixel and line buffer access.
module bds_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bds_pkg::PIX_W-1:0]       req_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bds_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bds_pkg::LOG2_W-1:0]      csr_data,
   input  logic                            s1_advance,
   output logic                            s1_valid,
   output bds_pkg::bds_ctl_type            s1_ctl,
   output logic [bds_pkg::PIX_W-1:0]       s1_left,
   output logic [bds_pkg::PIX_W-1:0]       s1_pix,
   output logic                            line_wr_en,
   output logic [bds_pkg::SLOT_W-1:0]      line_wr_addr,
   output logic [bds_pkg::LINE_W-1:0]      line_wr_data,
   output logic                            line_rd_en,
   output logic [bds_pkg::SLOT_W-1:0]      line_rd_addr
);
   import bds_pkg::*;

   logic [LOG2_W-1:0] width_log2_ff, width_log2_in;
   logic [LOG2_W-1:0] height_log2_ff, height_log2_in;
   logic [CNT_W-1:0]  column_count_ff, column_count_in;
   logic [CNT_W-1:0]  row_count_ff, row_count_in;
   logic [PIX_W-1:0]  left_pixel_ff, left_pixel_in;
   logic              s1_valid_ff, s1_valid_in;
   bds_ctl_type       s1_ctl_ff, s1_ctl_in;
   logic [PIX_W-1:0]  s1_left_ff, s1_left_in;
   logic [PIX_W-1:0]  s1_pix_ff, s1_pix_in;

   logic [LOG2_W-1:0] wl, hl;
   logic [CNT_W-1:0]  wmask, hmask, col, row;
   logic              accept, csr_write, restart;
   logic              err, one_d, two_d, last, store_left, emit;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign restart   = csr_write &&
                      (csr_index == REG_WIDTH_LOG2 || csr_index == REG_HEIGHT_LOG2);

   assign req_tready = !s1_valid_ff || s1_advance;
   assign accept     = req_tvalid && req_tready;

   // Clamp oversized sides and derive the raster position
   assign wl    = (width_log2_ff > MAX_LOG2_CFG) ? MAX_LOG2_CFG : width_log2_ff;
   assign hl    = (height_log2_ff > MAX_LOG2_CFG) ? MAX_LOG2_CFG : height_log2_ff;
   assign wmask = ~({CNT_W{1'b1}} << wl);
   assign hmask = ~({CNT_W{1'b1}} << hl);
   assign col   = column_count_ff & wmask;
   assign row   = row_count_ff & hmask;
   assign last  = (col == wmask) && (row == hmask);

   // Classify the pixel
   assign err        = (wl == '0) && (hl == '0);
   assign one_d      = !err && ((wl == '0) || (hl == '0));
   assign two_d      = !err && !one_d;
   assign store_left = (one_d && !(col[0] ^ row[0])) || (two_d && !col[0]);
   assign emit       = err || (one_d && (col[0] ^ row[0])) || (two_d && col[0] && row[0]);

   // Line buffer: even row stores pair sums, odd row fetches them
   assign line_wr_en   = accept && two_d && col[0] && !row[0];
   assign line_wr_addr = col[CNT_W-1:1];
   assign line_rd_en   = accept && two_d && col[0] && row[0];
   assign line_rd_addr = col[CNT_W-1:1];

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         line_wr_data[c*PAIR_W +: PAIR_W] =
            {1'b0, left_pixel_ff[c*CHAN_W +: CHAN_W]} + {1'b0, req_tdata[c*CHAN_W +: CHAN_W]};
      end
   end

   // Next state of configuration, counters and left pixel
   always_comb begin
      width_log2_in   = width_log2_ff;
      height_log2_in  = height_log2_ff;
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      left_pixel_in   = left_pixel_ff;
      if (restart) begin
         case (csr_index)
            REG_WIDTH_LOG2:  width_log2_in  = csr_data;
            REG_HEIGHT_LOG2: height_log2_in = csr_data;
            default:         ;
         endcase
         column_count_in = '0;
         row_count_in    = '0;
         left_pixel_in   = '0;
      end else if (accept && !err) begin
         if (store_left) begin
            left_pixel_in = req_tdata;
         end
         if (col == wmask) begin
            column_count_in = '0;
            row_count_in    = (row == hmask) ? '0 : row + CNT_W'(1);
         end else begin
            column_count_in = col + CNT_W'(1);
            row_count_in    = row;
         end
      end
   end

   // Stage register towards the averaging stage
   always_comb begin
      s1_valid_in = accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
      s1_ctl_in   = s1_ctl_ff;
      s1_left_in  = s1_left_ff;
      s1_pix_in   = s1_pix_ff;
      if (accept) begin
         s1_ctl_in.emit  = emit;
         s1_ctl_in.err   = err;
         s1_ctl_in.two_d = two_d;
         s1_ctl_in.last  = last;
         s1_left_in      = left_pixel_ff;
         s1_pix_in       = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_log2_ff   <= LOG2_RESET;
         height_log2_ff  <= LOG2_RESET;
         column_count_ff <= '0;
         row_count_ff    <= '0;
         left_pixel_ff   <= '0;
         s1_valid_ff     <= 1'b0;
         s1_ctl_ff       <= '0;
      end else begin
         width_log2_ff   <= width_log2_in;
         height_log2_ff  <= height_log2_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         left_pixel_ff   <= left_pixel_in;
         s1_valid_ff     <= s1_valid_in;
         s1_ctl_ff       <= s1_ctl_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      s1_left_ff <= s1_left_in;
      s1_pix_ff  <= s1_pix_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1_ctl   = s1_ctl_ff;
   assign s1_left  = s1_left_ff;
   assign s1_pix   = s1_pix_ff;

endmodule

// ----- rtl/bds_average.sv -----
// Averaging stage: per-channel pair or 2x2 averages into the result register.
module bds_average (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      s1_valid,
   input  bds_pkg::bds_ctl_type      s1_ctl,
   input  logic [bds_pkg::PIX_W-1:0] s1_left,
   input  logic [bds_pkg::PIX_W-1:0] s1_pix,
   input  logic [bds_pkg::LINE_W-1:0] above,
   output logic                      s1_advance,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [bds_pkg::PIX_W-1:0] rsp_tdata,
   output logic                      rsp_tlast,
   output logic                      rsp_tuser
);
   import bds_pkg::*;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_user_ff, rsp_user_in;
   logic             load;
   logic [PIX_W-1:0] avg;

   // Pass on when the stage emits nothing, or when the result slot is free or being emptied
   assign s1_advance = !s1_ctl.emit || !rsp_valid_ff || rsp_tready;
   assign load       = s1_valid && s1_ctl.emit && (!rsp_valid_ff || rsp_tready);

   // Per-channel averages, truncating
   always_comb begin
      logic [PAIR_W-1:0] pair;
      logic [PAIR_W:0]   quad;
      for (int c = 0; c < CHANNELS; c++) begin
         pair = {1'b0, s1_left[c*CHAN_W +: CHAN_W]} + {1'b0, s1_pix[c*CHAN_W +: CHAN_W]};
         quad = {1'b0, above[c*PAIR_W +: PAIR_W]} + {1'b0, pair};
         if (s1_ctl.err) begin
            avg[c*CHAN_W +: CHAN_W] = '0;
         end else if (s1_ctl.two_d) begin
            avg[c*CHAN_W +: CHAN_W] = quad[PAIR_W:2];
         end else begin
            avg[c*CHAN_W +: CHAN_W] = pair[PAIR_W-1:1];
         end
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = load ? avg : rsp_data_ff;
      rsp_last_in  = load ? (s1_ctl.last && !s1_ctl.err) : rsp_last_ff;
      rsp_user_in  = load ? s1_ctl.err : rsp_user_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
